// ===== design/limit_order_book_matcher_macros.svh =====
// Assertion macros used by the matcher design file.
`ifndef LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define LOBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define LOBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lobm_pkg.sv =====
package lobm_pkg;

  localparam int PRICE_W      = 20;
  localparam int QTY_W        = 16;
  localparam int ID_PORT_W    = 16;
  localparam int STOCK_PORT_W = 14;
  localparam int HALF_W       = 21;
  localparam int KIND_W       = 3;

  localparam int ORDER_SLOTS_DEF = 32;
  localparam int ID_BITS_DEF     = 16;
  localparam int STOCK_BITS_DEF  = 14;

  localparam logic [KIND_W-1:0] KIND_ACK       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEAL      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BOOK_FULL = 3'd4;
  localparam logic [KIND_W-1:0] KIND_IDS_GONE  = 3'd5;

  typedef enum logic [1:0] {
    OP_BEST   = 2'd0,
    OP_CANCEL = 2'd1,
    OP_FREE   = 2'd2
  } scan_op_t;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_LOAD = 2'd1,
    WR_QTY  = 2'd2,
    WR_CLR  = 2'd3
  } wr_kind_t;

  typedef struct packed {
    scan_op_t op;
    wr_kind_t wr;
  } cell_cmd_t;

  typedef struct packed {
    logic                    req_type;
    logic [STOCK_PORT_W-1:0] stock_id;
    logic [PRICE_W-1:0]      limit_price;
    logic [QTY_W-1:0]        order_qty;
    logic                    order_side;
    logic [ID_PORT_W-1:0]    cancel_id;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0]       result_kind;
    logic [ID_PORT_W-1:0]    first_id;
    logic [ID_PORT_W-1:0]    second_id;
    logic [STOCK_PORT_W-1:0] book_stock;
    logic [PRICE_W-1:0]      order_price;
    logic [HALF_W-1:0]       deal_price_half;
    logic [QTY_W-1:0]        deal_qty;
    logic                    which_side;
    logic                    last;
  } res_t;

endpackage

// ===== design/lobm_if.sv =====
interface lobm_req_if;
  logic              valid;
  logic              ready;
  lobm_pkg::req_t    data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface lobm_res_if;
  logic              valid;
  logic              ready;
  lobm_pkg::res_t    data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== design/lobm_cell.sv =====
module lobm_cell #(
  parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF,
  parameter int ID_BITS     = lobm_pkg::ID_BITS_DEF,
  parameter int STOCK_BITS  = lobm_pkg::STOCK_BITS_DEF,
  parameter int CELL_IDX    = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lobm_pkg::cell_cmd_t                  cmd,
  input  logic [STOCK_BITS-1:0]                q_stock,
  input  logic                                 q_side,
  input  logic [lobm_pkg::ID_PORT_W-1:0]       q_cid,
  input  logic [$clog2(ORDER_SLOTS)-1:0]       wr_idx,
  input  logic [STOCK_BITS-1:0]                wr_stock,
  input  logic [ID_BITS-1:0]                   wr_id,
  input  logic [lobm_pkg::PRICE_W-1:0]         wr_price,
  input  logic [lobm_pkg::QTY_W-1:0]           wr_qty,
  input  logic                                 wr_side,
  input  logic                                 ci_found,
  input  logic [$clog2(ORDER_SLOTS)-1:0]       ci_idx,
  input  logic [STOCK_BITS-1:0]                ci_stock,
  input  logic [ID_BITS-1:0]                   ci_id,
  input  logic [lobm_pkg::PRICE_W-1:0]         ci_price,
  input  logic [lobm_pkg::QTY_W-1:0]           ci_qty,
  input  logic                                 ci_side,
  output logic                                 co_found,
  output logic [$clog2(ORDER_SLOTS)-1:0]       co_idx,
  output logic [STOCK_BITS-1:0]                co_stock,
  output logic [ID_BITS-1:0]                   co_id,
  output logic [lobm_pkg::PRICE_W-1:0]         co_price,
  output logic [lobm_pkg::QTY_W-1:0]           co_qty,
  output logic                                 co_side
);

  localparam int IDX_W = $clog2(ORDER_SLOTS);
  localparam int CMP_W = (ID_BITS > lobm_pkg::ID_PORT_W) ? ID_BITS : lobm_pkg::ID_PORT_W;
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                          valid_r;
  logic [STOCK_BITS-1:0]         stock_r;
  logic [ID_BITS-1:0]            id_r;
  logic [lobm_pkg::PRICE_W-1:0]  price_r;
  logic [lobm_pkg::QTY_W-1:0]    qty_r;
  logic                          side_r;

  logic                          found_r;
  logic [IDX_W-1:0]              idx_r;
  logic [STOCK_BITS-1:0]         cstock_r;
  logic [ID_BITS-1:0]            cid_r;
  logic [lobm_pkg::PRICE_W-1:0]  cprice_r;
  logic [lobm_pkg::QTY_W-1:0]    cqty_r;
  logic                          cside_r;

  logic match;
  logic better;
  logic take;

  always_comb begin
    case (cmd.op)
      lobm_pkg::OP_BEST:   match = valid_r && stock_r == q_stock && side_r == q_side;
      lobm_pkg::OP_CANCEL: match = valid_r && CMP_W'(id_r) == CMP_W'(q_cid) && q_cid != '0;
      lobm_pkg::OP_FREE:   match = !valid_r;
      default:             match = 1'b0;
    endcase
    if (price_r == ci_price) begin
      better = id_r < ci_id;
    end else if (q_side) begin
      better = price_r < ci_price;
    end else begin
      better = price_r > ci_price;
    end
    take = match && (!ci_found || (cmd.op == lobm_pkg::OP_BEST && better));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= ci_found || take;
    end
    idx_r    <= take ? MY_IDX  : ci_idx;
    cstock_r <= take ? stock_r : ci_stock;
    cid_r    <= take ? id_r    : ci_id;
    cprice_r <= take ? price_r : ci_price;
    cqty_r   <= take ? qty_r   : ci_qty;
    cside_r  <= take ? side_r  : ci_side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_idx == MY_IDX) begin
      case (cmd.wr)
        lobm_pkg::WR_LOAD: valid_r <= 1'b1;
        lobm_pkg::WR_QTY:  valid_r <= wr_qty != '0;
        lobm_pkg::WR_CLR:  valid_r <= 1'b0;
        default:           valid_r <= valid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_idx == MY_IDX && cmd.wr == lobm_pkg::WR_LOAD) begin
      stock_r <= wr_stock;
      id_r    <= wr_id;
      price_r <= wr_price;
      side_r  <= wr_side;
    end
    if (wr_idx == MY_IDX && (cmd.wr == lobm_pkg::WR_LOAD || cmd.wr == lobm_pkg::WR_QTY)) begin
      qty_r <= wr_qty;
    end
  end

  assign co_found = found_r;
  assign co_idx   = idx_r;
  assign co_stock = cstock_r;
  assign co_id    = cid_r;
  assign co_price = cprice_r;
  assign co_qty   = cqty_r;
  assign co_side  = cside_r;

endmodule

// ===== design/limit_order_book_matcher.sv =====
// Limit order book matcher. Requests arrive on in_req (valid/ready), results
// leave on out_res (valid/ready); a request is taken when valid and ready are
// both high. A new order yields an acknowledgement, then one deal per crossed
// resting order, then possibly a book-full report; a cancel yields one result.
// The final result of each request has last set.
// Resting orders live in a row of ORDER_SLOTS cells. Each search for the best
// opposite order, a cancel id or a free slot passes a candidate down the row,
// one cell per cycle. A new order that finds the ids run out yields only an
// ids-gone report and is neither searched nor booked.
// Requests are handled one at a time; in_req.ready is high only when idle.
// Results pass through one output register; a stalled receiver holds the
// block at the next result until out_res.ready rises, and nothing is lost.
// Reset empties the book and sets the next id to one, with no clearing pass.
`include "limit_order_book_matcher_macros.svh"
module limit_order_book_matcher #(
  parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF,
  parameter int ID_BITS     = lobm_pkg::ID_BITS_DEF,
  parameter int STOCK_BITS  = lobm_pkg::STOCK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lobm_req_if.sink    in_req,
  lobm_res_if.source  out_res
);

  localparam int IDX_W = $clog2(ORDER_SLOTS);
  localparam int CNT_W = $clog2(ORDER_SLOTS + 1);
  localparam int PW    = lobm_pkg::PRICE_W;
  localparam int QW    = lobm_pkg::QTY_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_DEAL = 6'b000100,
    S_FREE = 6'b001000,
    S_CAN  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  lobm_pkg::scan_op_t           op_r, op_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [ID_BITS-1:0]           next_id_r, next_id_nxt;
  logic [ID_BITS-1:0]           id_r, id_nxt;
  logic [STOCK_BITS-1:0]        stock_r, stock_nxt;
  logic [PW-1:0]                price_r, price_nxt;
  logic [QW-1:0]                qty_r, qty_nxt;
  logic                         side_r, side_nxt;
  logic [lobm_pkg::ID_PORT_W-1:0] cid_r, cid_nxt;
  lobm_pkg::res_t               pend_r, pend_nxt;
  logic                         out_valid_r, out_valid_nxt;
  lobm_pkg::res_t               out_data_r, out_data_nxt;

  lobm_pkg::cell_cmd_t          cmd;
  logic [IDX_W-1:0]             wr_idx;
  logic [QW-1:0]                wr_qty;

  logic                         c_found [ORDER_SLOTS+1];
  logic [IDX_W-1:0]             c_idx   [ORDER_SLOTS+1];
  logic [STOCK_BITS-1:0]        c_stock [ORDER_SLOTS+1];
  logic [ID_BITS-1:0]           c_id    [ORDER_SLOTS+1];
  logic [PW-1:0]                c_price [ORDER_SLOTS+1];
  logic [QW-1:0]                c_qty   [ORDER_SLOTS+1];
  logic                         c_side  [ORDER_SLOTS+1];

  logic                         can_emit;
  logic                         emit;
  lobm_pkg::res_t               emit_data;
  logic                         scan_done;
  logic [PW-1:0]                buy_p, sell_p;
  logic                         crossed;
  logic [QW-1:0]                dq;
  logic [QW-1:0]                qty_left;
  lobm_pkg::res_t               res_zero;

  assign c_found[0] = 1'b0;
  assign c_idx[0]   = '0;
  assign c_stock[0] = '0;
  assign c_id[0]    = '0;
  assign c_price[0] = '0;
  assign c_qty[0]   = '0;
  assign c_side[0]  = 1'b0;

  for (genvar k = 0; k < ORDER_SLOTS; k++) begin : g_cell
    lobm_cell #(
      .ORDER_SLOTS(ORDER_SLOTS), .ID_BITS(ID_BITS), .STOCK_BITS(STOCK_BITS), .CELL_IDX(k)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd),
      .q_stock(stock_r), .q_side(op_r == lobm_pkg::OP_BEST ? ~side_r : side_r),
      .q_cid(cid_r), .wr_idx(wr_idx), .wr_stock(stock_r), .wr_id(id_r),
      .wr_price(price_r), .wr_qty(wr_qty), .wr_side(side_r),
      .ci_found(c_found[k]), .ci_idx(c_idx[k]), .ci_stock(c_stock[k]), .ci_id(c_id[k]),
      .ci_price(c_price[k]), .ci_qty(c_qty[k]), .ci_side(c_side[k]),
      .co_found(c_found[k+1]), .co_idx(c_idx[k+1]), .co_stock(c_stock[k+1]),
      .co_id(c_id[k+1]), .co_price(c_price[k+1]), .co_qty(c_qty[k+1]),
      .co_side(c_side[k+1])
    );
  end

  assign in_req.ready  = state_r == S_IDLE;
  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;
  assign can_emit      = !out_valid_r || out_res.ready;
  assign scan_done     = cnt_r == CNT_W'(ORDER_SLOTS);

  always_comb begin
    buy_p    = side_r ? c_price[ORDER_SLOTS] : price_r;
    sell_p   = side_r ? price_r : c_price[ORDER_SLOTS];
    crossed  = c_found[ORDER_SLOTS] && buy_p >= sell_p;
    if (qty_r == '0 || c_qty[ORDER_SLOTS] < qty_r) begin
      dq = c_qty[ORDER_SLOTS];
    end else begin
      dq = qty_r;
    end
    qty_left = qty_r - dq;
  end

  always_comb begin
    res_zero      = '0;
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    next_id_nxt   = next_id_r;
    id_nxt        = id_r;
    stock_nxt     = stock_r;
    price_nxt     = price_r;
    qty_nxt       = qty_r;
    side_nxt      = side_r;
    cid_nxt       = cid_r;
    pend_nxt      = pend_r;
    emit          = 1'b0;
    emit_data     = pend_r;
    cmd.op        = op_r;
    cmd.wr        = lobm_pkg::WR_NONE;
    wr_idx        = c_idx[ORDER_SLOTS];
    wr_qty        = c_qty[ORDER_SLOTS] - dq;
    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          stock_nxt = STOCK_BITS'(in_req.data.stock_id);
          price_nxt = in_req.data.limit_price;
          qty_nxt   = in_req.data.order_qty;
          side_nxt  = in_req.data.order_side;
          cid_nxt   = in_req.data.cancel_id;
          cnt_nxt   = '0;
          if (in_req.data.req_type) begin
            op_nxt    = lobm_pkg::OP_CANCEL;
            state_nxt = S_SCAN;
          end else if (next_id_r == '0) begin
            pend_nxt             = res_zero;
            pend_nxt.result_kind = lobm_pkg::KIND_IDS_GONE;
            state_nxt            = S_FIN;
          end else begin
            id_nxt               = next_id_r;
            next_id_nxt          = next_id_r + 1'b1;
            pend_nxt             = res_zero;
            pend_nxt.result_kind = lobm_pkg::KIND_ACK;
            pend_nxt.first_id    = lobm_pkg::ID_PORT_W'(next_id_r);
            op_nxt               = lobm_pkg::OP_BEST;
            state_nxt            = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (scan_done) begin
          cnt_nxt = cnt_r;
          case (op_r)
            lobm_pkg::OP_BEST:   state_nxt = S_DEAL;
            lobm_pkg::OP_FREE:   state_nxt = S_FREE;
            lobm_pkg::OP_CANCEL: state_nxt = S_CAN;
            default:             state_nxt = S_FIN;
          endcase
        end
      end
      S_DEAL: begin
        if (!crossed) begin
          if (qty_r != '0) begin
            op_nxt    = lobm_pkg::OP_FREE;
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (can_emit) begin
          emit                     = 1'b1;
          cmd.wr                   = lobm_pkg::WR_QTY;
          pend_nxt                 = res_zero;
          pend_nxt.result_kind     = lobm_pkg::KIND_DEAL;
          pend_nxt.first_id        = lobm_pkg::ID_PORT_W'(side_r ? c_id[ORDER_SLOTS] : id_r);
          pend_nxt.second_id       = lobm_pkg::ID_PORT_W'(side_r ? id_r : c_id[ORDER_SLOTS]);
          pend_nxt.book_stock      = lobm_pkg::STOCK_PORT_W'(stock_r);
          pend_nxt.deal_price_half = lobm_pkg::HALF_W'(buy_p) + lobm_pkg::HALF_W'(sell_p);
          pend_nxt.deal_qty        = dq;
          pend_nxt.which_side      = side_r;
          qty_nxt                  = qty_r == '0 ? qty_r : qty_left;
          cnt_nxt                  = '0;
          if (qty_r == '0 || qty_left == '0) begin
            qty_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_FREE: begin
        if (c_found[ORDER_SLOTS]) begin
          cmd.wr    = lobm_pkg::WR_LOAD;
          wr_qty    = qty_r;
          state_nxt = S_FIN;
        end else if (can_emit) begin
          emit                 = 1'b1;
          pend_nxt             = res_zero;
          pend_nxt.result_kind = lobm_pkg::KIND_BOOK_FULL;
          pend_nxt.first_id    = lobm_pkg::ID_PORT_W'(id_r);
          pend_nxt.deal_qty    = qty_r;
          state_nxt            = S_FIN;
        end
      end
      S_CAN: begin
        pend_nxt          = res_zero;
        pend_nxt.first_id = cid_r;
        if (c_found[ORDER_SLOTS]) begin
          cmd.wr               = lobm_pkg::WR_CLR;
          pend_nxt.result_kind = lobm_pkg::KIND_CANCELLED;
          pend_nxt.book_stock  = lobm_pkg::STOCK_PORT_W'(c_stock[ORDER_SLOTS]);
          pend_nxt.order_price = c_price[ORDER_SLOTS];
          pend_nxt.deal_qty    = c_qty[ORDER_SLOTS];
          pend_nxt.which_side  = c_side[ORDER_SLOTS];
        end else begin
          pend_nxt.result_kind = lobm_pkg::KIND_NOT_FOUND;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (can_emit) begin
          emit           = 1'b1;
          emit_data.last = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= lobm_pkg::OP_BEST;
      cnt_r       <= '0;
      next_id_r   <= ID_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    stock_r    <= stock_nxt;
    price_r    <= price_nxt;
    qty_r      <= qty_nxt;
    side_r     <= side_nxt;
    cid_r      <= cid_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  `LOBM_ASSERT_NXT(a_busy_after_accept, in_req.valid && in_req.ready, !in_req.ready,
                   "request accepted while busy")
  `LOBM_ASSERT_NXT(a_fin_to_idle, state_r == S_FIN && can_emit, state_r == S_IDLE,
                   "final result did not end the request")
  `LOBM_ASSERT_NXT(a_id_hold, !(in_req.valid && in_req.ready), $stable(next_id_r),
                   "next id moved without a request")
  `LOBM_ASSERT_IMP(a_scan_bound, state_r == S_SCAN, cnt_r <= CNT_W'(ORDER_SLOTS),
                   "search counter overran the row")

endmodule
